/* hw/rtl/bffa_pkg.sv */
`timescale 1ns / 1ps

package bffa_pkg;

    // default geometry
    localparam int DEF_NUM_BLOCKS   = 4096;
    localparam int DEF_BLOCK_SHIFT  = 12;
    localparam int DEF_RECORD_SLOTS = 64;

    // bitmap word: one memory word holds MAP_W block bits
    localparam int MAP_SHIFT = 3;
    localparam int MAP_W     = 1 << MAP_SHIFT;

    // payload widths
    localparam int SIZE_W   = 25;
    localparam int ADDR_W   = 64;
    localparam int STATUS_W = 2;
    localparam int FREED_W  = 13;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOSLOT   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

endpackage

/* hw/rtl/bitmap_first_fit_block_allocator_unit.sv */
`timescale 1ns / 1ps

// First-fit block allocator over a heap of NUM_BLOCKS blocks of 2^BLOCK_SHIFT
// bytes. An allocate item rounds size_bytes up to whole blocks, scans the
// used-block bitmap from block zero for the first run of that many free
// blocks, stores start and count in the lowest empty record slot, marks the
// run used and returns base_address + start * 2^BLOCK_SHIFT. A free item maps
// its address back to a block, finds the lowest occupied record starting
// there, clears the run and the record and returns the block count. Exactly
// one result item per input item. The bitmap lives in a memory of 8-bit words
// and the records in a second memory, each with one read and one write port,
// and one item is in work at a time (s_ready is low meanwhile). Each item is
// decoded; an allocate then scans the bitmap (8 blocks per word read),
// searches the records (one slot per read), does a read-modify-write of each
// bitmap word touched by the run and loads the result register; a free skips
// the bitmap scan. Failed requests stop at the step that fails and change
// nothing. After reset both memories are swept to zero, one word and one slot
// per cycle; no item is taken during that sweep, but base_address can be
// written at any time. The result register lets a new item be accepted while
// the previous result still waits for m_ready.

module bitmap_first_fit_block_allocator_unit #(
    parameter int NUM_BLOCKS   = bffa_pkg::DEF_NUM_BLOCKS,
    parameter int BLOCK_SHIFT  = bffa_pkg::DEF_BLOCK_SHIFT,
    parameter int RECORD_SLOTS = bffa_pkg::DEF_RECORD_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // base address register
    input  logic                          cfg_wr_en,
    input  logic [bffa_pkg::ADDR_W-1:0]   cfg_wr_data,

    // request items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [bffa_pkg::SIZE_W-1:0]   s_size_bytes,
    input  logic [bffa_pkg::ADDR_W-1:0]   s_free_address,

    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bffa_pkg::STATUS_W-1:0] m_status,
    output logic [bffa_pkg::ADDR_W-1:0]   m_alloc_address,
    output logic [bffa_pkg::FREED_W-1:0]  m_freed_blocks
);

    import bffa_pkg::*;

    // geometry
    localparam int NUM_WORDS = (NUM_BLOCKS + MAP_W - 1) / MAP_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = WADDR_W + MAP_SHIFT;
    localparam int RUN_W     = $clog2(NUM_BLOCKS + 1);
    localparam int SLOT_W    = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
    localparam int CLR_N     = (NUM_WORDS > RECORD_SLOTS) ? NUM_WORDS : RECORD_SLOTS;
    localparam int CLR_W     = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int NEED_W    = SIZE_W + 1;

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(RECORD_SLOTS - 1);
    localparam logic [CLR_W-1:0]   LAST_CLR  = CLR_W'(CLR_N - 1);

    typedef struct packed {
        logic [RUN_W-1:0] count;
        logic [IDX_W-1:0] start;
    } rec_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SLOT,
        S_MARK_RD,
        S_MARK_WR,
        S_RESP
    } state_t;

    // memories
    logic [MAP_W-1:0] map_mem [NUM_WORDS];
    rec_t             rec_mem [RECORD_SLOTS];

    logic               map_rd_en;
    logic [WADDR_W-1:0] map_rd_addr;
    logic [MAP_W-1:0]   map_rd_data;
    logic               map_wr_en;
    logic [WADDR_W-1:0] map_wr_addr;
    logic [MAP_W-1:0]   map_wr_data;

    logic               rec_rd_en;
    logic [SLOT_W-1:0]  rec_rd_addr;
    rec_t               rec_rd_data;
    logic               rec_wr_en;
    logic [SLOT_W-1:0]  rec_wr_addr;
    rec_t               rec_wr_data;

    // control and working registers
    state_t               state_reg;
    logic [CLR_W-1:0]     clr_reg;
    logic [ADDR_W-1:0]    base_reg;
    req_t                 req_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [RUN_W-1:0]     cnt_reg;
    logic [RUN_W-1:0]     run_reg;
    logic [IDX_W-1:0]     first_reg;
    logic [IDX_W-1:0]     last_reg;
    logic [WADDR_W-1:0]   scan_word_reg;
    logic [WADDR_W-1:0]   mark_word_reg;
    logic [SLOT_W-1:0]    slot_reg;
    status_t              res_status_reg;

    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [ADDR_W-1:0]    m_alloc_address_reg;
    logic [FREED_W-1:0]   m_freed_blocks_reg;

    // decode arithmetic
    logic [NEED_W-1:0]    need_sum;
    logic [NEED_W-1:0]    need;
    logic                 need_bad;
    logic [ADDR_W-1:0]    free_diff;
    logic [ADDR_W-1:0]    free_off;
    logic                 free_bad;

    // scan of one bitmap word
    logic [RUN_W-1:0]     scan_run;
    logic                 scan_hit;
    logic [MAP_SHIFT-1:0] scan_pos;
    logic [IDX_W-1:0]     scan_end;
    logic [IDX_W-1:0]     scan_first;

    // record match and run mask
    logic                 slot_hit;
    logic [MAP_W-1:0]     mark_mask;

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_alloc_address = m_alloc_address_reg;
    assign m_freed_blocks  = m_freed_blocks_reg;

    // blocks needed and free address to block index
    always_comb begin
        need_sum  = {1'b0, size_reg} + NEED_W'((1 << BLOCK_SHIFT) - 1);
        need      = need_sum >> BLOCK_SHIFT;
        need_bad  = (need == '0) || (32'(need) > NUM_BLOCKS);
        free_diff = addr_reg - base_reg;
        free_off  = free_diff >> BLOCK_SHIFT;
        free_bad  = (free_off >= ADDR_W'(NUM_BLOCKS));
    end

    // running free-run count over the 8 bits of the word just read
    always_comb begin
        logic [IDX_W-1:0] g;
        logic             used;
        scan_run = run_reg;
        scan_hit = 1'b0;
        scan_pos = '0;
        for (int b = 0; b < MAP_W; b++) begin
            g    = {scan_word_reg, MAP_SHIFT'(b)};
            // bits past the heap end count as used
            used = map_rd_data[b] || (32'(g) >= NUM_BLOCKS);
            if (used) begin
                scan_run = '0;
            end else begin
                scan_run = scan_run + RUN_W'(1);
            end
            if (!scan_hit && (scan_run == cnt_reg)) begin
                scan_hit = 1'b1;
                scan_pos = MAP_SHIFT'(b);
            end
        end
        scan_end   = {scan_word_reg, scan_pos};
        scan_first = IDX_W'(32'(scan_end) + 32'd1 - 32'(cnt_reg));
    end

    // alloc wants an empty slot, free wants an occupied one at the index
    always_comb begin
        if (req_reg == REQ_ALLOC) begin
            slot_hit = (rec_rd_data.count == '0);
        end else begin
            slot_hit = (rec_rd_data.count != '0) && (rec_rd_data.start == first_reg);
        end
    end

    // bits of the current word that fall inside the run
    always_comb begin
        logic [IDX_W-1:0] g;
        for (int b = 0; b < MAP_W; b++) begin
            g            = {mark_word_reg, MAP_SHIFT'(b)};
            mark_mask[b] = (g >= first_reg) && (g <= last_reg);
        end
    end

    // memory port control
    always_comb begin
        map_rd_en   = 1'b0;
        map_rd_addr = '0;
        map_wr_en   = 1'b0;
        map_wr_addr = '0;
        map_wr_data = '0;
        rec_rd_en   = 1'b0;
        rec_rd_addr = '0;
        rec_wr_en   = 1'b0;
        rec_wr_addr = '0;
        rec_wr_data = '0;
        case (state_reg)
            S_CLEAR: begin
                map_wr_en   = (32'(clr_reg) < NUM_WORDS);
                map_wr_addr = WADDR_W'(clr_reg);
                rec_wr_en   = (32'(clr_reg) < RECORD_SLOTS);
                rec_wr_addr = SLOT_W'(clr_reg);
            end
            S_DECODE: begin
                map_rd_en = 1'b1;
                rec_rd_en = 1'b1;
            end
            S_SCAN: begin
                map_rd_en   = (scan_word_reg != LAST_WORD);
                map_rd_addr = scan_word_reg + WADDR_W'(1);
                rec_rd_en   = 1'b1;
            end
            S_SLOT: begin
                rec_rd_en   = (slot_reg != LAST_SLOT);
                rec_rd_addr = slot_reg + SLOT_W'(1);
                rec_wr_en   = slot_hit;
                rec_wr_addr = slot_reg;
                if (req_reg == REQ_ALLOC) begin
                    rec_wr_data.count = cnt_reg;
                    rec_wr_data.start = first_reg;
                end
            end
            S_MARK_RD: begin
                map_rd_en   = 1'b1;
                map_rd_addr = mark_word_reg;
            end
            S_MARK_WR: begin
                map_wr_en   = 1'b1;
                map_wr_addr = mark_word_reg;
                if (req_reg == REQ_ALLOC) begin
                    map_wr_data = map_rd_data | mark_mask;
                end else begin
                    map_wr_data = map_rd_data & ~mark_mask;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (map_wr_en) begin
            map_mem[map_wr_addr] <= map_wr_data;
        end
        if (map_rd_en) begin
            map_rd_data <= map_mem[map_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_wr_en) begin
            rec_mem[rec_wr_addr] <= rec_wr_data;
        end
        if (rec_rd_en) begin
            rec_rd_data <= rec_mem[rec_rd_addr];
        end
    end

    // base address register, writable at any time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the response state loads the result register itself
            if (m_ready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + CLR_W'(1);
                    if (clr_reg == LAST_CLR) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= req_t'(s_req_type);
                        size_reg  <= s_size_bytes;
                        addr_reg  <= s_free_address;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    scan_word_reg <= '0;
                    slot_reg      <= '0;
                    run_reg       <= '0;
                    cnt_reg       <= RUN_W'(need);
                    first_reg     <= IDX_W'(free_off);
                    if (req_reg == REQ_ALLOC) begin
                        if (need_bad) begin
                            res_status_reg <= ST_NOSPACE;
                            state_reg      <= S_RESP;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end else begin
                        if (free_bad) begin
                            res_status_reg <= ST_NOTFOUND;
                            state_reg      <= S_RESP;
                        end else begin
                            state_reg <= S_SLOT;
                        end
                    end
                end
                S_SCAN: begin
                    run_reg       <= scan_run;
                    scan_word_reg <= scan_word_reg + WADDR_W'(1);
                    if (scan_hit) begin
                        first_reg <= scan_first;
                        last_reg  <= scan_end;
                        state_reg <= S_SLOT;
                    end else if (scan_word_reg == LAST_WORD) begin
                        res_status_reg <= ST_NOSPACE;
                        state_reg      <= S_RESP;
                    end
                end
                S_SLOT: begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                    if (slot_hit) begin
                        mark_word_reg <= first_reg[IDX_W-1:MAP_SHIFT];
                        res_status_reg <= ST_OK;
                        state_reg     <= S_MARK_RD;
                        if (req_reg == REQ_FREE) begin
                            cnt_reg  <= rec_rd_data.count;
                            last_reg <= IDX_W'(32'(first_reg) + 32'(rec_rd_data.count) - 32'd1);
                        end
                    end else if (slot_reg == LAST_SLOT) begin
                        res_status_reg <= (req_reg == REQ_ALLOC) ? ST_NOSLOT : ST_NOTFOUND;
                        state_reg      <= S_RESP;
                    end
                end
                S_MARK_RD: begin
                    state_reg <= S_MARK_WR;
                end
                S_MARK_WR: begin
                    mark_word_reg <= mark_word_reg + WADDR_W'(1);
                    if (mark_word_reg == last_reg[IDX_W-1:MAP_SHIFT]) begin
                        state_reg <= S_RESP;
                    end else begin
                        state_reg <= S_MARK_RD;
                    end
                end
                S_RESP: begin
                    // hold here while the previous result is still waiting
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        if (res_status_reg == ST_OK && req_reg == REQ_ALLOC) begin
                            m_alloc_address_reg <= base_reg
                                + (ADDR_W'(first_reg) << BLOCK_SHIFT);
                        end else begin
                            m_alloc_address_reg <= '0;
                        end
                        if (res_status_reg == ST_OK && req_reg == REQ_FREE) begin
                            m_freed_blocks_reg <= FREED_W'(cnt_reg);
                        end else begin
                            m_freed_blocks_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a nonzero release count only comes from a successful free
    a_freed_only_on_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_freed_blocks != '0) |-> (m_status == ST_OK && m_alloc_address == '0))
        else $error("release count on a result that is not a successful free");

    // failures report neither an address nor a release count
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_alloc_address == '0 && m_freed_blocks == '0))
        else $error("failed result carries address or count");

    // run update never runs past the run's last word
    a_mark_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MARK_WR) |->
            (first_reg <= last_reg && mark_word_reg <= last_reg[IDX_W-1:MAP_SHIFT]))
        else $error("bitmap update outside the run");

    // a record written by allocate is never left looking empty
    a_rec_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SLOT && rec_wr_en && req_reg == REQ_ALLOC) |->
            (rec_wr_data.count != '0))
        else $error("allocate stored an empty record");

    // a free only reaches the bitmap after matching an occupied record
    a_free_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SLOT && req_reg == REQ_FREE && slot_hit) |=>
            (state_reg == S_MARK_RD && cnt_reg != '0))
        else $error("free entered bitmap update without a record");

endmodule
